>>> src/offset_index_deque_assert.svh
// Assertion macros for the offset index deque.
`ifndef OFFSET_INDEX_DEQUE_ASSERT_SVH
`define OFFSET_INDEX_DEQUE_ASSERT_SVH

// Common clocking and reset qualifier.
`define OFFDQ_CLK_RST(clk, rstn) @(posedge clk) disable iff (!rstn)

// Concurrent assertion, reported through $error.
`define OFFDQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (`OFFDQ_CLK_RST(clk, rstn) prop) else $error(msg);

`endif

>>> src/offdq_pkg.sv
`default_nettype none

package offdq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT   = 3'd0,
    CMD_PUSH_BACK    = 3'd1,
    CMD_ADD_ALL      = 3'd2,
    CMD_REMOVE_FRONT = 3'd3,
    CMD_REMOVE_BACK  = 3'd4,
    CMD_CLEAR        = 3'd5,
    CMD_REBASE       = 3'd6
  } cmd_e;

  typedef logic [31:0] word_t;

  localparam int unsigned CountOutW = 7;

endpackage

`default_nettype wire

>>> src/offdq_ram.sv
`default_nettype none

module offdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> src/offset_index_deque.sv
// A command accepted at one edge passes through the input register, the
//   pointer/write stage with the RAM read, and the output register before its result shows.
// Throughput: one command per cycle; busy is high only in the cycle after reset.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset clears pointers, count, global offset and the pipeline valids; the
// entry RAM is not cleared.
`default_nettype none

module offset_index_deque import offdq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] value_i,
  output logic               result_valid_o,
  output logic [6:0]         count_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic               push_dropped_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] x);
    logic [SW-1:0] y;
    y = (x >= SW'(DEPTH)) ? (x - SW'(DEPTH)) : x;
    return y[AW-1:0];
  endfunction

  logic          busy_q;
  logic          s1_valid_q;
  cmd_e          s1_cmd_q;
  word_t         s1_val_q;

  logic [AW-1:0] head_q, head_d, head_dec;
  logic [CW-1:0] count_q, count_d, rm_n;
  word_t         offset_q, offset_d;

  logic          s2_valid_q, s2_front_byp_q, s2_back_byp_q, s2_dropped_q;
  word_t         s2_wdata_q;
  word_t         front_raw_q, back_raw_q;

  logic          res_valid_q, dropped_out_q;
  logic [6:0]    count_out_q;
  word_t         front_out_q, back_out_q;

  logic          accept, full, empty, rm_pos, rm_all, dropped;
  logic          we;
  logic [AW-1:0] waddr, front_addr, back_addr;
  word_t         wdata, rd_front, rd_back;
  word_t         front_raw_s2, back_raw_s2, front_cur, back_cur;
  logic [31:0]   cnt_ext;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  assign front_raw_s2 = s2_front_byp_q ? s2_wdata_q : rd_front;
  assign back_raw_s2  = s2_back_byp_q ? s2_wdata_q : rd_back;
  assign front_cur    = s2_valid_q ? front_raw_s2 : front_raw_q;
  assign back_cur     = s2_valid_q ? back_raw_s2 : back_raw_q;

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : (head_q - AW'(1));

  assign rm_pos = !s1_val_q[31] && (s1_val_q != '0);
  assign rm_all = (|s1_val_q[30:CW]) || (s1_val_q[CW-1:0] >= count_q);
  assign rm_n   = !rm_pos ? '0 : (rm_all ? count_q : s1_val_q[CW-1:0]);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    offset_d = offset_q;
    we       = 1'b0;
    waddr    = head_q;
    wdata    = word_t'(0) - offset_q;
    dropped  = 1'b0;
    if (s1_valid_q) begin
      case (s1_cmd_q)
        CMD_PUSH_FRONT: begin
          if (full) begin
            dropped = 1'b1;
          end else begin
            head_d  = head_dec;
            count_d = count_q + CW'(1);
            we      = 1'b1;
            waddr   = head_dec;
            if (!empty) begin
              wdata = front_cur - s1_val_q;
            end
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            dropped = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
            we      = 1'b1;
            waddr   = wrap_slot(SW'(head_q) + SW'(count_q));
            if (!empty) begin
              wdata = back_cur + s1_val_q;
            end
          end
        end
        CMD_ADD_ALL: begin
          offset_d = offset_q + s1_val_q;
        end
        CMD_REMOVE_FRONT: begin
          head_d  = wrap_slot(SW'(head_q) + SW'(rm_n));
          count_d = count_q - rm_n;
        end
        CMD_REMOVE_BACK: begin
          count_d = count_q - rm_n;
        end
        CMD_CLEAR: begin
          count_d = '0;
        end
        CMD_REBASE: begin
          if (!empty) begin
            offset_d = word_t'(0) - front_cur;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign front_addr = head_d;
  assign back_addr  = (count_d == '0) ? head_d
                                      : wrap_slot(SW'(head_d) + SW'(count_d) - SW'(1));

  offdq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_offdq_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(front_addr),
    .rdata_a_o(rd_front),
    .raddr_b_i(back_addr),
    .rdata_b_o(rd_back)
  );

  assign cnt_ext = 32'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      offset_q    <= '0;
    end else begin
      busy_q      <= 1'b0;
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      res_valid_q <= s2_valid_q;
      head_q      <= head_d;
      count_q     <= count_d;
      offset_q    <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= cmd_e'(command_i);
      s1_val_q <= word_t'(value_i);
    end
    s2_front_byp_q <= we && (waddr == front_addr);
    s2_back_byp_q  <= we && (waddr == back_addr);
    s2_wdata_q     <= wdata;
    s2_dropped_q   <= dropped;
    if (s2_valid_q) begin
      front_raw_q <= front_raw_s2;
      back_raw_q  <= back_raw_s2;
    end
    count_out_q   <= cnt_ext[CountOutW-1:0];
    front_out_q   <= empty ? '1 : (front_raw_s2 + offset_q);
    back_out_q    <= empty ? '1 : (back_raw_s2 + offset_q);
    dropped_out_q <= s2_dropped_q;
  end

  assign result_valid_o = res_valid_q;
  assign count_o        = count_out_q;
  assign front_value_o  = front_out_q;
  assign back_value_o   = back_out_q;
  assign push_dropped_o = dropped_out_q;

endmodule

`default_nettype wire

>>> src/offdq_checker.sv
`default_nettype none
`include "offset_index_deque_assert.svh"

module offdq_checker import offdq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [2:0]         command_i,
  input logic signed [31:0] value_i,
  input logic               result_valid_o,
  input logic [6:0]         count_o,
  input logic signed [31:0] front_value_o,
  input logic signed [31:0] back_value_o,
  input logic               push_dropped_o
);

  localparam bit CountExact = (DEPTH < 128);

  `OFFDQ_ASSERT(a_beat_gives_result, clk_i, rst_ni,
                (start && !busy) |-> ##3 result_valid_o,
                "accepted beat produced no result")
  `OFFDQ_ASSERT(a_result_has_beat, clk_i, rst_ni,
                result_valid_o |-> $past(start && !busy, 3),
                "result without an accepted beat")
  `OFFDQ_ASSERT(a_empty_reads_minus_one, clk_i, rst_ni,
                (result_valid_o && CountExact && count_o == '0) |->
                  (front_value_o == -32'sd1 && back_value_o == -32'sd1),
                "empty queue must report -1 at both ends")
  `OFFDQ_ASSERT(a_drop_only_on_push, clk_i, rst_ni,
                (result_valid_o && push_dropped_o) |->
                  ($past(command_i, 3) == CMD_PUSH_FRONT ||
                   $past(command_i, 3) == CMD_PUSH_BACK),
                "drop flagged for a non-push command")

endmodule

bind offset_index_deque offdq_checker #(.DEPTH(DEPTH)) u_offdq_checker (.*);

`default_nettype wire
